// File: src/stt_pkg.sv
`default_nettype none

package stt_pkg;

   // widths of the item fields
   localparam int BYTE_W     = 8;
   localparam int LINE_BITS  = 24;
   localparam int LINE_OUT_W = 24;
   localparam int RSP_DATA_W = 32;

   // result queue size
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // character codes
   localparam logic [BYTE_W-1:0] CHR_CR    = 8'h0d;
   localparam logic [BYTE_W-1:0] CHR_LF    = 8'h0a;
   localparam logic [BYTE_W-1:0] CHR_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CHR_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CHR_HASH  = 8'h23;
   localparam logic [BYTE_W-1:0] CHR_STAR  = 8'h2a;
   localparam logic [BYTE_W-1:0] CHR_DOT   = 8'h2e;
   localparam logic [BYTE_W-1:0] CHR_SLASH = 8'h2f;
   localparam logic [BYTE_W-1:0] CHR_BSL   = 8'h5c;
   localparam logic [BYTE_W-1:0] CHR_DIG0  = 8'd48;
   localparam logic [BYTE_W-1:0] CHR_DIG9  = 8'd57;
   localparam logic [BYTE_W-1:0] CHR_UPA   = 8'd65;
   localparam logic [BYTE_W-1:0] CHR_UPZ   = 8'd90;
   localparam logic [BYTE_W-1:0] CHR_UNDER = 8'd95;
   localparam logic [BYTE_W-1:0] CHR_LOA   = 8'd97;
   localparam logic [BYTE_W-1:0] CHR_LOZ   = 8'd122;

   // one token byte on the result side
   typedef struct packed {
      logic [LINE_OUT_W-1:0] line_number;
      logic                  token_last;
      logic [BYTE_W-1:0]     token_byte;
   } stt_beat_type;

   // results of one step: count and up to two beats in order
   typedef struct packed {
      logic [1:0]   count;
      stt_beat_type beat1;
      stt_beat_type beat0;
   } stt_res_type;

endpackage

`default_nettype wire

// File: src/source_text_tokenizer.sv
`default_nettype none

// channel   dir  tdata                             tuser       tlast
// req_      in   [7:0] in_byte                     allow_dot   stream_end
// rsp_      out  [7:0] token_byte, [31:8] line_no  -           token_last
//
// one byte is taken per cycle unless the input stalls; a taken byte waits
// in the input register, then its beats are written into the result queue
// a byte makes up to two result beats; the port drains one per cycle while
// rsp_tready is high, so a long run of two-beat bytes settles to the output rate
// reset clears the tokenizer state, the line count and the result queue
// the input stalls only when the four-entry result queue lacks room for two

module source_text_tokenizer
   import stt_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [BYTE_W-1:0]     req_tdata,   // [7:0] in_byte
   input  wire logic                  req_tuser,   // allow_dot
   input  wire logic                  req_tlast,   // stream_end
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // [7:0] token_byte, [31:8] line_number
   output logic                       rsp_tlast    // token_last
);

   logic                   in_vld_ff;
   logic [BYTE_W-1:0]      in_byte_ff;
   logic                   in_dot_ff;
   logic                   in_end_ff;
   logic                   advance;
   logic [QUEUE_CNT_W-1:0] fill;
   stt_res_type            results;
   stt_beat_type           out_beat;

   // input stage moves on when the queue has room for a two-beat byte
   assign advance    = in_vld_ff && (fill <= QUEUE_CNT_W'(QUEUE_DEPTH - 2));
   assign req_tready = !in_vld_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_dot_ff  <= req_tuser;
         in_end_ff  <= req_tlast;
      end
   end

   stt_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step_en    (advance),
      .in_byte    (in_byte_ff),
      .allow_dot  (in_dot_ff),
      .stream_end (in_end_ff),
      .results    (results)
   );

   stt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (results),
      .pop_valid (rsp_tvalid),
      .pop_ready (rsp_tready),
      .pop_beat  (out_beat),
      .fill      (fill)
   );

   // result beat packing
   assign rsp_tdata = {out_beat.line_number, out_beat.token_byte};
   assign rsp_tlast = out_beat.token_last;

`ifndef SYNTHESIS
   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !advance |=> in_vld_ff && $stable(in_byte_ff) && $stable(in_end_ff))
      else $error("stalled input stage lost its byte");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      fill == '0 |-> req_tready)
      else $error("input stalled with empty result queue");

   a_out_follows_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid == (fill != '0))
      else $error("result valid disagrees with queue fill");
`endif

endmodule

`default_nettype wire

// File: src/stt_core.sv
`default_nettype none

module stt_core
   import stt_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step_en,
   input  wire logic [BYTE_W-1:0] in_byte,
   input  wire logic              allow_dot,
   input  wire logic              stream_end,
   output stt_res_type            results
);

   logic [BYTE_W-1:0]    held_byte_ff,  held_byte_in;
   logic                 holding_ff,    holding_in;
   logic                 slash_ff,      slash_in;
   logic                 line_cmt_ff,   line_cmt_in;
   logic                 block_cmt_ff,  block_cmt_in;
   logic [1:0]           block_seen_ff, block_seen_in;
   logic                 star_ff,       star_in;
   logic                 after_cr_ff,   after_cr_in;
   logic [LINE_BITS-1:0] line_ff,       line_in;

   stt_beat_type beats [2];
   logic [1:0]   emit_cnt;

   function automatic logic is_word(input logic [BYTE_W-1:0] c);
      return (c >= CHR_DIG0 && c <= CHR_DIG9) || (c >= CHR_UPA && c <= CHR_UPZ) ||
             c == CHR_UNDER || (c >= CHR_LOA && c <= CHR_LOZ);
   endfunction

   function automatic logic is_blank(input logic [BYTE_W-1:0] c);
      return c == CHR_SPACE || c == CHR_TAB || c == CHR_LF;
   endfunction

   // one byte through newline folding, comment tracking and run building
   always_comb begin
      logic [BYTE_W-1:0] c;
      logic              swallow;
      logic              plain;

      c             = in_byte;
      held_byte_in  = held_byte_ff;
      holding_in    = holding_ff;
      slash_in      = slash_ff;
      line_cmt_in   = line_cmt_ff;
      block_cmt_in  = block_cmt_ff;
      block_seen_in = block_seen_ff;
      star_in       = star_ff;
      line_in       = line_ff;
      emit_cnt      = 2'd0;
      plain         = 1'b0;
      beats[0]      = '0;
      beats[1]      = '0;

      swallow     = (c == CHR_LF) && after_cr_ff;
      after_cr_in = (c == CHR_CR);

      if (!swallow) begin
         // newline count, saturating
         if (c == CHR_CR || c == CHR_LF) begin
            if (line_ff != '1) begin
               line_in = line_ff + 1'b1;
            end
            c = CHR_LF;
         end

         if (line_cmt_ff) begin
            if (c == CHR_LF) begin
               line_cmt_in = 1'b0;
            end
         end else if (block_cmt_ff) begin
            if (block_seen_ff != 2'd0 && star_ff && c == CHR_SLASH) begin
               block_cmt_in = 1'b0;
            end else begin
               star_in = (c == CHR_STAR);
               if (block_seen_ff != 2'd2) begin
                  block_seen_in = block_seen_ff + 2'd1;
               end
            end
         end else begin
            plain = 1'b1;
            // pending slash opens a comment or stands alone
            if (slash_ff) begin
               slash_in = 1'b0;
               if (c == CHR_SLASH) begin
                  line_cmt_in = 1'b1;
                  plain       = 1'b0;
               end else if (c == CHR_STAR) begin
                  block_cmt_in  = 1'b1;
                  block_seen_in = 2'd0;
                  star_in       = 1'b0;
                  plain         = 1'b0;
               end else begin
                  beats[emit_cnt[0]].token_byte = CHR_SLASH;
                  beats[emit_cnt[0]].token_last = 1'b1;
                  emit_cnt = emit_cnt + 2'd1;
               end
            end

            // ordinary byte
            if (plain && c != CHR_BSL) begin
               if ((allow_dot && c == CHR_DOT) || is_word(c)) begin
                  if (holding_in) begin
                     beats[emit_cnt[0]].token_byte = held_byte_in;
                     beats[emit_cnt[0]].token_last = 1'b0;
                     emit_cnt = emit_cnt + 2'd1;
                  end
                  held_byte_in = c;
                  holding_in   = 1'b1;
               end else begin
                  if (holding_in) begin
                     beats[emit_cnt[0]].token_byte = held_byte_in;
                     beats[emit_cnt[0]].token_last = 1'b1;
                     emit_cnt   = emit_cnt + 2'd1;
                     holding_in = 1'b0;
                  end
                  if (!is_blank(c)) begin
                     if (c == CHR_SLASH) begin
                        slash_in = 1'b1;
                     end else if (c == CHR_HASH) begin
                        held_byte_in = c;
                        holding_in   = 1'b1;
                     end else begin
                        beats[emit_cnt[0]].token_byte = c;
                        beats[emit_cnt[0]].token_last = 1'b1;
                        emit_cnt = emit_cnt + 2'd1;
                     end
                  end
               end
            end
         end
      end

      // end of input flushes the held byte and a pending slash
      if (stream_end) begin
         if (holding_in) begin
            beats[emit_cnt[0]].token_byte = held_byte_in;
            beats[emit_cnt[0]].token_last = 1'b1;
            emit_cnt = emit_cnt + 2'd1;
         end
         if (slash_in) begin
            beats[emit_cnt[0]].token_byte = CHR_SLASH;
            beats[emit_cnt[0]].token_last = 1'b1;
            emit_cnt = emit_cnt + 2'd1;
         end
         holding_in    = 1'b0;
         slash_in      = 1'b0;
         line_cmt_in   = 1'b0;
         block_cmt_in  = 1'b0;
         block_seen_in = 2'd0;
         star_in       = 1'b0;
         after_cr_in   = 1'b0;
      end

      beats[0].line_number = LINE_OUT_W'(line_in);
      beats[1].line_number = LINE_OUT_W'(line_in);
   end

   assign results.count = step_en ? emit_cnt : 2'd0;
   assign results.beat0 = beats[0];
   assign results.beat1 = beats[1];

   // tokenizer state
   always_ff @(posedge clock) begin
      if (reset) begin
         held_byte_ff  <= '0;
         holding_ff    <= 1'b0;
         slash_ff      <= 1'b0;
         line_cmt_ff   <= 1'b0;
         block_cmt_ff  <= 1'b0;
         block_seen_ff <= 2'd0;
         star_ff       <= 1'b0;
         after_cr_ff   <= 1'b0;
         line_ff       <= '0;
      end else if (step_en) begin
         held_byte_ff  <= held_byte_in;
         holding_ff    <= holding_in;
         slash_ff      <= slash_in;
         line_cmt_ff   <= line_cmt_in;
         block_cmt_ff  <= block_cmt_in;
         block_seen_ff <= block_seen_in;
         star_ff       <= star_in;
         after_cr_ff   <= after_cr_in;
         line_ff       <= line_in;
      end
   end

`ifndef SYNTHESIS
   a_comment_kinds_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(line_cmt_ff && block_cmt_ff))
      else $error("line and block comment open together");

   a_slash_not_in_comment: assert property (@(posedge clock) disable iff (reset)
      !(slash_ff && (line_cmt_ff || block_cmt_ff || holding_ff)))
      else $error("pending slash alongside comment or held byte");

   a_end_clears_state: assert property (@(posedge clock) disable iff (reset)
      step_en && stream_end |=> !holding_ff && !slash_ff && !line_cmt_ff && !block_cmt_ff)
      else $error("end of input left tokenizer state open");

   a_line_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> line_ff >= $past(line_ff))
      else $error("line count went backward");
`endif

endmodule

`default_nettype wire

// File: src/stt_queue.sv
`default_nettype none

module stt_queue
   import stt_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire stt_res_type  push,
   output logic              pop_valid,
   input  wire logic         pop_ready,
   output stt_beat_type      pop_beat,
   output logic [QUEUE_CNT_W-1:0] fill
);

   stt_beat_type                entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]      fill_ff,   fill_in;
   logic                        pop;
   logic [QUEUE_PTR_W-1:0]      wr_next;

   assign pop       = pop_valid && pop_ready;
   assign pop_valid = (fill_ff != '0);
   assign pop_beat  = entries_ff[rd_ptr_ff];
   assign fill      = fill_ff;
   assign wr_next   = wr_ptr_ff + 1'b1;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + QUEUE_PTR_W'(pop);
      fill_in   = fill_ff + QUEUE_CNT_W'(push.count) - QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // up to two beats written in order
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push.beat0;
      end
      if (push.count == 2'd2) begin
         entries_ff[wr_next] <= push.beat1;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("result queue overflow");

   a_push_fits: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> fill_ff + QUEUE_CNT_W'(push.count) <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("push into full result queue");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      fill_ff == '0 || fill_ff == QUEUE_CNT_W'(QUEUE_DEPTH) ||
      QUEUE_PTR_W'(wr_ptr_ff - rd_ptr_ff) == QUEUE_PTR_W'(fill_ff))
      else $error("queue pointers disagree with fill");
`endif

endmodule

`default_nettype wire

// File: tb/sv/tb_source_text_tokenizer.sv
`timescale 1ns / 100ps

import stt_pkg::*;

// predicts the token beats of the tokenizer and holds the beats still due
class token_tracker;
   stt_beat_type          beats_due[$];
   logic [BYTE_W-1:0]     held;
   bit                    holding;
   bit                    slash_pend;
   bit                    in_line_cmt;
   bit                    in_block_cmt;
   logic [1:0]            block_seen;
   bit                    prev_star;
   bit                    after_cr;
   logic [LINE_BITS-1:0]  line_cnt;
   int                    bytes_taken;
   int                    beats_checked;
   int                    errors;

   function new();
      held = '0;
      holding = 0;
      slash_pend = 0;
      in_line_cmt = 0;
      in_block_cmt = 0;
      block_seen = '0;
      prev_star = 0;
      after_cr = 0;
      line_cnt = '0;
      bytes_taken = 0;
      beats_checked = 0;
      errors = 0;
   endfunction

   function void queue_beat(logic [BYTE_W-1:0] b, bit last);
      stt_beat_type beat;
      beat.token_byte  = b;
      beat.token_last  = last;
      beat.line_number = LINE_OUT_W'(line_cnt);
      beats_due.push_back(beat);
   endfunction

   function bit is_word_char(logic [BYTE_W-1:0] c);
      return (c >= CHR_DIG0 && c <= CHR_DIG9) || (c >= CHR_UPA && c <= CHR_UPZ) ||
             c == CHR_UNDER || (c >= CHR_LOA && c <= CHR_LOZ);
   endfunction

   // byte outside any comment or pending slash
   function void plain_byte(logic [BYTE_W-1:0] c, bit dot);
      if (c == CHR_BSL)
         return;
      if ((dot && c == CHR_DOT) || is_word_char(c)) begin
         if (holding)
            queue_beat(held, 0);
         held = c;
         holding = 1;
         return;
      end
      if (holding) begin
         queue_beat(held, 1);
         holding = 0;
      end
      if (c == CHR_SPACE || c == CHR_TAB || c == CHR_LF)
         return;
      if (c == CHR_SLASH) begin
         slash_pend = 1;
      end else if (c == CHR_HASH) begin
         held = c;
         holding = 1;
      end else begin
         queue_beat(c, 1);
      end
   endfunction

   // comment tracking ahead of the plain byte path
   function void scan_byte(logic [BYTE_W-1:0] c, bit dot);
      if (in_line_cmt) begin
         if (c == CHR_LF)
            in_line_cmt = 0;
         return;
      end
      if (in_block_cmt) begin
         if (block_seen != 0 && prev_star && c == CHR_SLASH) begin
            in_block_cmt = 0;
         end else begin
            prev_star = (c == CHR_STAR);
            if (block_seen < 2)
               block_seen++;
         end
         return;
      end
      if (slash_pend) begin
         slash_pend = 0;
         if (c == CHR_SLASH) begin
            in_line_cmt = 1;
            return;
         end
         if (c == CHR_STAR) begin
            in_block_cmt = 1;
            block_seen = '0;
            prev_star = 0;
            return;
         end
         queue_beat(CHR_SLASH, 1);
      end
      plain_byte(c, dot);
   endfunction

   // note one accepted text byte and queue the beats it causes
   function void take_text_byte(logic [BYTE_W-1:0] raw, bit dot, bit final_byte);
      logic [BYTE_W-1:0] c;
      bit                swallow;
      c = raw;
      swallow = (c == CHR_LF && after_cr);
      after_cr = (c == CHR_CR);
      bytes_taken++;
      if (!swallow) begin
         if (c == CHR_CR || c == CHR_LF) begin
            if (line_cnt != {LINE_BITS{1'b1}})
               line_cnt++;
            c = CHR_LF;
         end
         scan_byte(c, dot);
      end
      // end of input flushes the held byte, then a pending slash
      if (final_byte) begin
         if (holding)
            queue_beat(held, 1);
         if (slash_pend)
            queue_beat(CHR_SLASH, 1);
         holding = 0;
         slash_pend = 0;
         in_line_cmt = 0;
         in_block_cmt = 0;
         block_seen = '0;
         prev_star = 0;
         after_cr = 0;
      end
   endfunction

   // compare one output beat with the oldest expected beat
   function void match_token_beat(logic [BYTE_W-1:0] b, bit last,
                                  logic [LINE_OUT_W-1:0] line_no);
      stt_beat_type want;
      beats_checked++;
      if (beats_due.size() == 0) begin
         errors++;
         $error("token beat with none expected: byte %02h last %0d line %0d",
                b, last, line_no);
         return;
      end
      want = beats_due.pop_front();
      if (want.token_byte !== b) begin
         errors++;
         $error("token_byte: expected %02h, actual %02h", want.token_byte, b);
      end
      if (want.token_last !== last) begin
         errors++;
         $error("token_last: expected %0d, actual %0d", want.token_last, last);
      end
      if (want.line_number !== line_no) begin
         errors++;
         $error("line_number: expected %0d, actual %0d", want.line_number, line_no);
      end
   endfunction
endclass

module tb_source_text_tokenizer;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              dot_ok;
      logic              is_final;
   } text_item_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [BYTE_W-1:0]     req_tdata;   // [7:0] in_byte
   logic                  req_tuser;   // allow_dot
   logic                  req_tlast;   // stream_end
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // [7:0] token_byte, [31:8] line_number
   logic                  rsp_tlast;   // token_last

   text_item_type text_q[$];
   token_tracker  tracker;
   int            final_bytes;

   source_text_tokenizer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // clock
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("source_text_tokenizer regression: fail");
      $finish;
   end

   task automatic add_byte(logic [BYTE_W-1:0] b, bit dot, bit fin);
      text_item_type it;
      it.data = b;
      it.dot_ok = dot;
      it.is_final = fin;
      text_q.push_back(it);
   endtask

   task automatic add_text(string s, bit dot);
      for (int i = 0; i < s.len(); i++)
         add_byte(s[i], dot, 0);
   endtask

   function automatic logic [BYTE_W-1:0] word_char();
      case ($urandom_range(0, 3))
         0: return CHR_DIG0 + BYTE_W'($urandom_range(0, 9));
         1: return CHR_UPA + BYTE_W'($urandom_range(0, 25));
         2: return CHR_LOA + BYTE_W'($urandom_range(0, 25));
         default: return CHR_UNDER;
      endcase
   endfunction

   function automatic logic [BYTE_W-1:0] comment_char();
      case ($urandom_range(0, 7))
         0, 1: return CHR_STAR;
         2: return CHR_SLASH;
         3: return ($urandom_range(0, 1) != 0) ? CHR_CR : CHR_LF;
         default: return BYTE_W'($urandom_range(8'h20, 8'h7e));
      endcase
   endfunction

   // short directed text: joins, blanks, newlines, comments, odd bytes, flush
   task automatic build_directed();
      add_text("#Az_9.", 1);
      add_text(".\t", 0);
      add_text("a\\\r\n\r", 0);
      add_text("//\n", 0);
      add_text("/*/*/", 0);
      add_text("/a", 0);
      add_byte(8'h00, 0, 0);
      add_byte(8'hff, 1, 0);
      add_byte("z", 0, 1);
      add_byte(CHR_SLASH, 0, 1);
   endtask

   // random text: mostly well-formed tokens and comments, some noise
   task automatic build_random(int count);
      int  stop_at;
      int  start;
      int  n;
      bit  dot;
      stop_at = text_q.size() + count;
      while (text_q.size() < stop_at) begin
         start = text_q.size();
         dot = 1'($urandom_range(0, 1));
         case ($urandom_range(0, 11))
            0, 1: begin
               n = $urandom_range(1, 8);
               repeat (n) add_byte(word_char(), dot, 0);
            end
            2: begin
               n = $urandom_range(1, 6);
               repeat (n)
                  add_byte(($urandom_range(0, 3) == 0) ? CHR_DOT :
                           CHR_DIG0 + BYTE_W'($urandom_range(0, 9)), 1, 0);
            end
            3: begin
               add_byte(CHR_HASH, dot, 0);
               n = $urandom_range(0, 5);
               repeat (n) add_byte(word_char(), dot, 0);
            end
            4: begin
               case ($urandom_range(0, 4))
                  0: add_byte(CHR_SPACE, dot, 0);
                  1: add_byte(CHR_TAB, dot, 0);
                  2: add_byte(CHR_CR, dot, 0);
                  3: add_byte(CHR_LF, dot, 0);
                  default: begin
                     add_byte(CHR_CR, dot, 0);
                     add_byte(CHR_LF, dot, 0);
                  end
               endcase
            end
            5: begin
               add_text("//", dot);
               n = $urandom_range(0, 10);
               repeat (n) add_byte(BYTE_W'($urandom_range(8'h20, 8'h7e)), dot, 0);
               add_byte(($urandom_range(0, 1) != 0) ? CHR_CR : CHR_LF, dot, 0);
            end
            6: begin
               add_text("/*", dot);
               n = $urandom_range(0, 10);
               repeat (n) add_byte(comment_char(), dot, 0);
               add_text("*/", dot);
            end
            7: add_byte(BYTE_W'($urandom_range(8'h21, 8'h7e)), dot, 0);
            8: add_byte(($urandom_range(0, 1) != 0) ? CHR_BSL : CHR_SLASH, dot, 0);
            9, 10: begin
               n = $urandom_range(1, 3);
               repeat (n)
                  add_byte(BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 0);
            end
            default: begin
               // comment cut short by the end of input
               add_text(($urandom_range(0, 1) != 0) ? "/*" : "//", dot);
               n = $urandom_range(0, 4);
               repeat (n) add_byte(comment_char(), dot, 0);
               text_q[text_q.size() - 1].is_final = 1'b1;
            end
         endcase
         if ($urandom_range(0, 24) == 0 && text_q.size() > start)
            text_q[text_q.size() - 1].is_final = 1'b1;
      end
   endtask

   // result side stalls on its own pattern
   initial begin
      int mode;
      int span;
      rsp_tready = 0;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(8, 64);
         for (int k = 0; k < span; k++) begin
            @(negedge clock);
            case (mode)
               0: rsp_tready = 1;
               1: rsp_tready = $urandom_range(0, 1);
               2: rsp_tready = (k % 4 == 0);
               default: rsp_tready = (k >= 20);
            endcase
         end
      end
   end

   // result beats checked as they are taken
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.match_token_beat(rsp_tdata[7:0], rsp_tlast, rsp_tdata[31:8]);
   end

   // text bytes driven in bursts with random gaps
   initial begin
      text_item_type item;
      int            burst_left;
      int            drain_wait;
      tracker = new();
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      req_tuser = 0;
      req_tlast = 0;
      final_bytes = 0;
      build_directed();
      build_random(1820);
      repeat (2) @(negedge clock);
      reset = 0;
      burst_left = $urandom_range(1, 12);
      while (text_q.size() != 0) begin
         if (burst_left == 0) begin
            req_tvalid = 0;
            repeat ($urandom_range(1, 7)) @(negedge clock);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120) :
                                                      $urandom_range(1, 12);
         end
         item = text_q.pop_front();
         req_tvalid = 1;
         req_tdata = item.data;
         req_tuser = item.dot_ok;
         req_tlast = item.is_final;
         do @(posedge clock); while (!req_tready);
         tracker.take_text_byte(item.data, item.dot_ok, item.is_final);
         if (item.is_final)
            final_bytes++;
         burst_left--;
         @(negedge clock);
      end
      req_tvalid = 0;

      // drain, then wait on for stray beats
      drain_wait = 0;
      while (tracker.beats_due.size() != 0 && drain_wait < 20000) begin
         @(posedge clock);
         drain_wait++;
      end
      if (tracker.beats_due.size() != 0) begin
         tracker.errors++;
         $error("%0d token beats never arrived", tracker.beats_due.size());
      end
      repeat (16) @(posedge clock);

      $display("sent %0d text bytes (%0d marked end of input), checked %0d token beats",
               tracker.bytes_taken, final_bytes, tracker.beats_checked);
      $display("words, numbers, directives, comments, newlines and raw bytes; %0d lines",
               tracker.line_cnt);
      if (tracker.errors == 0)
         $display("source_text_tokenizer regression: pass");
      else
         $display("source_text_tokenizer regression: fail");
      $finish;
   end

endmodule
